FILE: sv/sequenced_log_ring_buffer_assert.svh
// Assertion macros for the sequenced log ring buffer checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SEQUENCED_LOG_RING_BUFFER_ASSERT_SVH
`define SEQUENCED_LOG_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLRB_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("slrb: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SLRB_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("slrb: next-cycle check failed");

`endif

FILE: sv/slrb_pkg.sv
// Package of the sequenced log ring buffer: sizes, codes, request/result types.
// No dependencies.
`timescale 1ns / 1ps
package slrb_pkg;

  localparam int ENTRIES    = 16;
  localparam int TEXT_BYTES = 32;
  localparam int BUDGET_CAP = 64;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int PHYS_W = $clog2(ENTRIES + 1);
  localparam int OFF_W  = $clog2(TEXT_BYTES);
  localparam int LEN_W  = 6;
  localparam int TXT_DEPTH = 2 ** (PHYS_W + OFF_W);

  typedef enum logic [0:0] {
    REQ_APPEND = 1'b0,
    REQ_READ   = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] stamp_ms;
    logic [3:0]  source;
    logic [7:0]  text_byte;
    logic        text_last;
    logic [31:0] seq_after;
    logic [6:0]  read_limit;
    logic [6:0]  budget_bytes;
    logic [6:0]  out_capacity;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] sequence_res;
    logic [31:0] stamp_ms_res;
    logic [3:0]  source_res;
    logic [5:0]  text_len;
    logic [7:0]  text_byte_res;
    logic        entry_last;
    logic        run_last;
    logic [4:0]  entries_returned;
    logic [31:0] dropped_total;
  } res_t;

  // Handshake between front queue and back executor
  typedef struct packed {
    logic valid;
    req_t req;
  } cmd_t;

endpackage

FILE: sv/slrb_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module slrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/slrb_front.sv
// Front of the log ring buffer: accepts requests into a two-entry queue.
// Depends on slrb_pkg.
`timescale 1ns / 1ps
module slrb_front import slrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  input  logic pop_i,
  output cmd_t cmd_o
);

  logic [1:0] cnt_q;
  logic       wr_q, rd_q;
  req_t       slot_q [2];
  logic       push, pop;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != 2'd0);

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.req   = slot_q[rd_q];

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= req_i;
    end
  end

endmodule

FILE: sv/slrb_back.sv
// Back of the log ring buffer: commits appends and scans the ring for reads.
// Depends on slrb_pkg and slrb_ram.
`timescale 1ns / 1ps
module slrb_back import slrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_META, ST_BYTE, ST_DONE} state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] oldest_q;
  logic [CNT_W-1:0]  count_q;
  logic [31:0]       next_seq_q, drop_q;
  logic [LEN_W-1:0]  stage_len_q;
  logic [PHYS_W-1:0] spare_q;
  logic [PHYS_W-1:0] map_q [ENTRIES];

  // Slot metadata, indexed by ring position
  logic [31:0]      seq_q [ENTRIES];
  logic [31:0]      up_q  [ENTRIES];
  logic [3:0]       src_q [ENTRIES];
  logic [LEN_W-1:0] len_q [ENTRIES];

  // Read scan state
  logic [31:0]       after_q;
  logic [6:0]        limit_q, budget_q, copied_q, bytes_q;
  logic [CNT_W-1:0]  i_q;
  logic [SLOT_W-1:0] cur_q;
  logic [OFF_W-1:0]  b_q;
  logic              rdv_q, rdlast_q;
  logic              pend_v_q;
  res_t              pend_q, res_q;
  logic              res_v_q;

  logic [SLOT_W-1:0] sel_slot, tail_slot, wr_slot;
  logic [CNT_W:0]    sel_sum, tail_sum;
  logic              full, do_append, do_commit, do_read, stage_room;
  logic [LEN_W-1:0]  new_len, m_len;
  logic [31:0]       seq_inc, seq_nx;
  logic [7:0]        bytes_sum;
  logic [6:0]        lim_min, bud_min;
  logic              txt_we;
  logic [PHYS_W+OFF_W-1:0] txt_waddr, txt_raddr;
  logic [7:0]        txt_rdata;
  res_t              byte_res, ack_res, empty_res, res_d;
  logic              res_v_d;

  // Ring index arithmetic
  always_comb begin
    sel_sum   = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(i_q);
    tail_sum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);
    sel_slot  = (sel_sum >= (CNT_W+1)'(ENTRIES)) ?
                SLOT_W'(sel_sum - (CNT_W+1)'(ENTRIES)) : SLOT_W'(sel_sum);
    tail_slot = (tail_sum >= (CNT_W+1)'(ENTRIES)) ?
                SLOT_W'(tail_sum - (CNT_W+1)'(ENTRIES)) : SLOT_W'(tail_sum);
    full      = (count_q == CNT_W'(ENTRIES));
    wr_slot   = full ? oldest_q : tail_slot;
  end

  // Request decode
  assign pop_o      = cmd_i.valid && (state_q == ST_IDLE);
  assign do_append  = pop_o && (cmd_i.req.req_type == REQ_APPEND);
  assign do_commit  = do_append && cmd_i.req.text_last;
  assign do_read    = pop_o && (cmd_i.req.req_type == REQ_READ);
  assign stage_room = (stage_len_q < LEN_W'(TEXT_BYTES));
  assign new_len    = stage_len_q + LEN_W'(stage_room);
  assign seq_inc    = next_seq_q + 32'd1;
  assign seq_nx     = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
  assign m_len      = len_q[sel_slot];
  assign bytes_sum  = {1'b0, bytes_q} + 8'(m_len);
  assign lim_min    = (cmd_i.req.read_limit > cmd_i.req.out_capacity) ?
                      cmd_i.req.out_capacity : cmd_i.req.read_limit;
  assign bud_min    = (cmd_i.req.budget_bytes > 7'(BUDGET_CAP)) ?
                      7'(BUDGET_CAP) : cmd_i.req.budget_bytes;

  // Text store: staging bytes go straight into the spare physical slot
  assign txt_we    = do_append && stage_room;
  assign txt_waddr = {spare_q, stage_len_q[OFF_W-1:0]};
  assign txt_raddr = {map_q[cur_q], b_q};

  slrb_ram #(.WIDTH(8), .DEPTH(TXT_DEPTH)) u_text (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (txt_waddr),
    .wdata_i (cmd_i.req.text_byte),
    .raddr_i (txt_raddr),
    .rdata_o (txt_rdata)
  );

  // Result built from a returning text byte
  always_comb begin
    byte_res                  = '0;
    byte_res.kind             = KIND_BYTE;
    byte_res.sequence_res     = seq_q[cur_q];
    byte_res.stamp_ms_res     = up_q[cur_q];
    byte_res.source_res       = src_q[cur_q];
    byte_res.text_len         = len_q[cur_q];
    byte_res.text_byte_res    = txt_rdata;
    byte_res.entry_last       = rdlast_q;
    byte_res.entries_returned = copied_q[4:0];
    byte_res.dropped_total    = drop_q;
  end

  // Ack and empty-read results
  always_comb begin
    ack_res                 = '0;
    ack_res.kind            = KIND_ACK;
    ack_res.sequence_res    = next_seq_q;
    ack_res.run_last        = 1'b1;
    ack_res.dropped_total   = full ? drop_q + 32'd1 : drop_q;
    empty_res               = '0;
    empty_res.kind          = KIND_EMPTY;
    empty_res.run_last      = 1'b1;
    empty_res.dropped_total = drop_q;
  end

  // Next result: commit ack, a released byte, or the closing result of a read
  always_comb begin
    res_v_d = 1'b0;
    res_d   = '0;
    if (do_commit) begin
      res_v_d = 1'b1;
      res_d   = ack_res;
    end else if (rdv_q && pend_v_q) begin
      res_v_d = 1'b1;
      res_d   = pend_q;
    end else if (state_q == ST_DONE && !rdv_q) begin
      res_v_d        = 1'b1;
      res_d          = pend_v_q ? pend_q : empty_res;
      res_d.run_last = 1'b1;
    end
  end

  // Control and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      next_seq_q  <= 32'd1;
      drop_q      <= '0;
      stage_len_q <= '0;
      spare_q     <= PHYS_W'(ENTRIES);
      for (int k = 0; k < ENTRIES; k++) begin
        map_q[k] <= PHYS_W'(k);
      end
      i_q      <= '0;
      copied_q <= '0;
      bytes_q  <= '0;
      limit_q  <= '0;
      budget_q <= '0;
      cur_q    <= '0;
      b_q      <= '0;
      rdv_q    <= 1'b0;
      rdlast_q <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      res_q   <= res_d;
      rdv_q   <= (state_q == ST_BYTE);
      // Hold one byte back so the final one can carry run_last
      if (rdv_q) begin
        pend_v_q <= 1'b1;
        pend_q   <= byte_res;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (do_append) begin
            stage_len_q <= do_commit ? '0 : new_len;
          end
          if (do_commit) begin
            map_q[wr_slot] <= spare_q;
            spare_q        <= map_q[wr_slot];
            next_seq_q     <= seq_nx;
            if (full) begin
              oldest_q <= (oldest_q == SLOT_W'(ENTRIES - 1)) ? '0 : oldest_q + 1'b1;
              drop_q   <= drop_q + 32'd1;
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
          if (do_read) begin
            after_q  <= cmd_i.req.seq_after;
            limit_q  <= lim_min;
            budget_q <= bud_min;
            i_q      <= '0;
            copied_q <= '0;
            bytes_q  <= '0;
            pend_v_q <= 1'b0;
            state_q  <= ST_META;
          end
        end
        ST_META: begin
          priority if (i_q == count_q || copied_q == limit_q) begin
            state_q <= ST_DONE;
          end else if (seq_q[sel_slot] <= after_q) begin
            i_q <= i_q + 1'b1;
          end else if (copied_q != 7'd0 && bytes_sum > {1'b0, budget_q}) begin
            state_q <= ST_DONE;
          end else if (copied_q == 7'd0 && 7'(m_len) > budget_q) begin
            i_q <= i_q + 1'b1;
          end else begin
            copied_q <= copied_q + 7'd1;
            bytes_q  <= bytes_sum[6:0];
            cur_q    <= sel_slot;
            b_q      <= '0;
            state_q  <= ST_BYTE;
          end
        end
        ST_BYTE: begin
          rdlast_q <= (LEN_W'(b_q) + 1'b1 == len_q[cur_q]);
          b_q      <= b_q + 1'b1;
          if (LEN_W'(b_q) + 1'b1 == len_q[cur_q]) begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_META;
          end
        end
        ST_DONE: begin
          if (!rdv_q) begin
            state_q  <= ST_IDLE;
            pend_v_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Slot metadata written on commit
  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      seq_q[wr_slot] <= next_seq_q;
      up_q[wr_slot]  <= cmd_i.req.stamp_ms;
      src_q[wr_slot] <= cmd_i.req.source;
      len_q[wr_slot] <= new_len;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

FILE: sv/sequenced_log_ring_buffer.sv
// Top level of the sequenced log ring buffer.
// Depends on slrb_pkg, slrb_front, slrb_back.
//
// Usage: a request is taken at a clock edge with start high and busy low.
// An append request carries one text byte; the byte flagged text_last
// commits the entry and yields one ack result with its sequence number.
// A read request yields one result per returned text byte, or one empty
// result, the last flagged run_last. Results appear on res_o for a single
// cycle marked by res_valid_o; the receiver cannot stall them.
// An ack is registered onto res_o when the back pops and commits its
// request. Appends sustain one byte per cycle while no read is in progress.
// A read scans the ring from the oldest entry, one slot per cycle, and
// pauses the scan while the text RAM returns the bytes of a copied entry,
// one byte per cycle.
// busy rises when the two-entry request queue is full.
// Reset empties the ring, sets the next sequence to 1 and clears the drop
// count; no clearing pass is needed.
`timescale 1ns / 1ps
module sequenced_log_ring_buffer import slrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t cmd;
  logic pop;

  slrb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .pop_i  (pop),
    .cmd_o  (cmd)
  );

  slrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

FILE: sv/slrb_checker.sv
// Port-level checker for the sequenced log ring buffer, bound to the top.
// Depends on slrb_pkg and sequenced_log_ring_buffer_assert.svh.
`timescale 1ns / 1ps
`include "sequenced_log_ring_buffer_assert.svh"
module slrb_checker import slrb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_o,
  input res_t res_o
);

  logic kind_ok, is_byte, byte_ok;

  assign kind_ok = (res_o.kind == KIND_ACK) || (res_o.kind == KIND_BYTE) ||
                   (res_o.kind == KIND_EMPTY);
  assign is_byte = res_valid_o && (res_o.kind == KIND_BYTE);
  assign byte_ok = (res_o.entries_returned != 5'd0) && (res_o.text_len != 6'd0);

  // Only defined result kinds leave the block
  `SLRB_ASSERT_NOW(a_kind_ok, res_valid_o, kind_ok)
  // Acks and empty reads close their request
  `SLRB_ASSERT_NOW(a_single_last, res_valid_o && !is_byte, res_o.run_last && res_o.entries_returned == 5'd0)
  // A returned byte belongs to a counted entry
  `SLRB_ASSERT_NOW(a_byte_counted, is_byte, byte_ok)
  // A byte that does not end its run is not directly followed by an ack or empty result
  `SLRB_ASSERT_NEXT(a_run_cont, is_byte && !res_o.run_last, !res_valid_o || is_byte)

endmodule

bind sequenced_log_ring_buffer slrb_checker u_slrb_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench of sequenced_log_ring_buffer: directed table, then random traffic.
// Depends on slrb_pkg and the sequenced_log_ring_buffer RTL.
`timescale 1ns / 1ps
module testbench;
  import slrb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  sequenced_log_ring_buffer u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  // Predicted ring state
  logic [SLOT_W-1:0] ring_oldest;
  int unsigned ring_count;
  logic [31:0] ring_next_seq;
  logic [31:0] ring_drops;
  logic [31:0] ring_seq[ENTRIES];
  logic [31:0] ring_up[ENTRIES];
  logic [3:0] ring_src[ENTRIES];
  int unsigned ring_len[ENTRIES];
  logic [7:0] ring_text[ENTRIES][TEXT_BYTES];
  logic [7:0] stage_text[TEXT_BYTES];
  int unsigned stage_len;

  res_t log_results_due[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned reads_sent;
  int unsigned appends_sent;
  int unsigned cycles;

  typedef struct {
    req_t req;
    bit typed;
    res_t res;
  } table_row_t;

  function automatic req_t app(logic [7:0] b, logic last, logic [31:0] up, logic [3:0] src);
    req_t r;
    r = '0;
    r.req_type = REQ_APPEND;
    r.text_byte = b;
    r.text_last = last;
    r.stamp_ms = up;
    r.source = src;
    return r;
  endfunction

  function automatic req_t rd(logic [31:0] after, logic [6:0] lim, logic [6:0] bud,
                              logic [6:0] cap);
    req_t r;
    r = '0;
    r.req_type = REQ_READ;
    r.seq_after = after;
    r.read_limit = lim;
    r.budget_bytes = bud;
    r.out_capacity = cap;
    return r;
  endfunction

  function automatic res_t ack_res(logic [31:0] seq, logic [31:0] drops);
    res_t r;
    r = '0;
    r.kind = KIND_ACK;
    r.sequence_res = seq;
    r.run_last = 1'b1;
    r.dropped_total = drops;
    return r;
  endfunction

  function automatic res_t empty_res(logic [31:0] drops);
    res_t r;
    r = '0;
    r.kind = KIND_EMPTY;
    r.run_last = 1'b1;
    r.dropped_total = drops;
    return r;
  endfunction

  // Updates the predicted ring and queues the results of one request
  task automatic predict_log(input req_t r);
    int unsigned idx, lim, bud, copied, nbytes, len, n;
    res_t e;
    if (r.req_type == REQ_APPEND) begin
      if (stage_len < TEXT_BYTES) begin
        stage_text[stage_len] = r.text_byte;
        stage_len++;
      end
      if (!r.text_last) return;
      if (ring_count >= ENTRIES) begin
        idx = ring_oldest;
        ring_oldest = ring_oldest + 1'b1;
        ring_drops++;
      end else begin
        idx = (ring_oldest + ring_count) % ENTRIES;
        ring_count++;
      end
      ring_seq[idx] = ring_next_seq;
      ring_up[idx] = r.stamp_ms;
      ring_src[idx] = r.source;
      ring_len[idx] = stage_len;
      for (int i = 0; i < stage_len; i++) ring_text[idx][i] = stage_text[i];
      stage_len = 0;
      log_results_due.push_back(ack_res(ring_next_seq, ring_drops));
      ring_next_seq++;
      if (ring_next_seq == 0) ring_next_seq = 1;
      return;
    end
    // read: scan oldest to newest
    bud = (r.budget_bytes > BUDGET_CAP) ? BUDGET_CAP : r.budget_bytes;
    lim = (r.read_limit > r.out_capacity) ? r.out_capacity : r.read_limit;
    copied = 0;
    nbytes = 0;
    n = 0;
    for (int i = 0; i < ring_count && copied < lim; i++) begin
      idx = (ring_oldest + i) % ENTRIES;
      len = ring_len[idx];
      if (ring_seq[idx] <= r.seq_after) continue;
      if (copied > 0 && nbytes + len > bud) break;
      if (copied == 0 && len > bud) continue;
      copied++;
      nbytes += len;
      for (int b = 0; b < len && n < 64; b++) begin
        e = '0;
        e.kind = KIND_BYTE;
        e.sequence_res = ring_seq[idx];
        e.stamp_ms_res = ring_up[idx];
        e.source_res = ring_src[idx];
        e.text_len = len[5:0];
        e.text_byte_res = ring_text[idx][b];
        e.entry_last = (b + 1 == len);
        e.entries_returned = copied[4:0];
        e.dropped_total = ring_drops;
        log_results_due.push_back(e);
        n++;
      end
    end
    if (n == 0) log_results_due.push_back(empty_res(ring_drops));
    else log_results_due[$].run_last = 1'b1;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (log_results_due.size() == 0) begin
        report("unexpected result, kind", res_o.kind, '0);
      end else begin
        e = log_results_due.pop_front();
        if (res_o.kind !== e.kind) report("kind", res_o.kind, e.kind);
        if (res_o.sequence_res !== e.sequence_res)
          report("sequence_res", res_o.sequence_res, e.sequence_res);
        if (res_o.stamp_ms_res !== e.stamp_ms_res)
          report("stamp_ms_res", res_o.stamp_ms_res, e.stamp_ms_res);
        if (res_o.source_res !== e.source_res)
          report("source_res", res_o.source_res, e.source_res);
        if (res_o.text_len !== e.text_len)
          report("text_len", res_o.text_len, e.text_len);
        if (res_o.text_byte_res !== e.text_byte_res)
          report("text_byte_res", res_o.text_byte_res, e.text_byte_res);
        if (res_o.entry_last !== e.entry_last)
          report("entry_last", res_o.entry_last, e.entry_last);
        if (res_o.run_last !== e.run_last) report("run_last", res_o.run_last, e.run_last);
        if (res_o.entries_returned !== e.entries_returned)
          report("entries_returned", res_o.entries_returned, e.entries_returned);
        if (res_o.dropped_total !== e.dropped_total)
          report("dropped_total", res_o.dropped_total, e.dropped_total);
      end
    end
  end

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one request; optional idle gap first, then hold until accepted
  task automatic send_request(input req_t r, input int gap_pct, input bit typed,
                              input res_t want);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_log(r);
    if (typed) begin
      void'(log_results_due.pop_back());
      log_results_due.push_back(want);
    end
    if (r.req_type == REQ_READ) reads_sent++;
    else appends_sent++;
  endtask

  function automatic req_t random_read(int unsigned recent);
    logic [31:0] after;
    case ($urandom_range(3))
      0: after = 0;
      1: after = (recent > 20) ? recent - $urandom_range(20) : $urandom_range(recent);
      2: after = $urandom;
      default: after = 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(9) == 0)
      return rd(after, $urandom_range(1) ? 7'd0 : 7'($urandom_range(64)),
                7'($urandom_range(64)), $urandom_range(1) ? 7'd0 : 7'($urandom_range(64)));
    return rd(after, 7'($urandom_range(64, 1)), 7'($urandom_range(64)),
              7'($urandom_range(64, 1)));
  endfunction

  // Random phase: mostly whole entries, some reads, some mid-entry
  task automatic random_phase(input int items, input int gap_pct);
    int n, len;
    logic [31:0] up;
    logic [3:0] src;
    n = 0;
    while (n < items) begin
      if ($urandom_range(99) < 18) begin
        send_request(random_read(ring_next_seq), gap_pct, 1'b0, '0);
        n++;
      end else begin
        len = ($urandom_range(99) < 12) ? $urandom_range(40, 28) : $urandom_range(8, 1);
        up = $urandom;
        src = 4'($urandom);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 3) begin
            send_request(random_read(ring_next_seq), gap_pct, 1'b0, '0);
            n++;
          end
          send_request(app(8'($urandom), i == len - 1, up, src), gap_pct, 1'b0, '0);
          n++;
        end
      end
    end
  endtask

  table_row_t stim_table[$];

  initial begin
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    reads_sent = 0;
    appends_sent = 0;
    ring_oldest = '0;
    ring_count = 0;
    ring_next_seq = 1;
    ring_drops = 0;
    stage_len = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;

    // Directed rows; typed expectations only where obvious
    stim_table.push_back('{rd(0, 64, 64, 64), 1'b1, empty_res(0)});
    stim_table.push_back('{app(8'h00, 1, 32'h0, 4'h0), 1'b1, ack_res(1, 0)});
    stim_table.push_back('{app(8'hFF, 1, 32'hFFFF_FFFF, 4'hF), 1'b1, ack_res(2, 0)});
    stim_table.push_back('{app(8'h55, 0, 32'h0, 4'h0), 1'b0, '0});
    stim_table.push_back('{rd(0, 64, 64, 64), 1'b0, '0});
    stim_table.push_back('{app(8'hAA, 0, 32'h0, 4'h0), 1'b0, '0});
    stim_table.push_back('{app(8'h7E, 1, 32'h1234_5678, 4'hA), 1'b1, ack_res(3, 0)});
    stim_table.push_back('{rd(0, 64, 64, 64), 1'b0, '0});
    stim_table.push_back('{rd(0, 0, 64, 64), 1'b1, empty_res(0)});
    stim_table.push_back('{rd(0, 64, 64, 0), 1'b1, empty_res(0)});
    stim_table.push_back('{rd(32'hFFFF_FFFF, 64, 64, 64), 1'b1, empty_res(0)});
    stim_table.push_back('{rd(2, 64, 2, 64), 1'b1, empty_res(0)});
    stim_table.push_back('{rd(0, 64, 1, 64), 1'b0, '0});
    stim_table.push_back('{rd(0, 64, 0, 64), 1'b1, empty_res(0)});
    stim_table.push_back('{rd(1, 1, 127, 64), 1'b0, '0});
    stim_table.push_back('{rd(0, 127, 127, 2), 1'b0, '0});
    stim_table.push_back('{rd(0, 64, 5, 64), 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      send_request(stim_table[i].req, 0, stim_table[i].typed, stim_table[i].res);

    // Random phases at different sender idle rates
    random_phase(60, 0);
    random_phase(45, 75);
    random_phase(45, 17);
    random_phase(45, 0);
    start <= 1'b0;

    while (log_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d appended bytes and %0d reads; %0d results checked, %0d drops.",
             appends_sent, reads_sent, results_seen, ring_drops);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
